/* rtl/ipp_pkg.sv */
// ----------------------------------------------------------------------------
// ipp_pkg
// types and codes shared by the instance placement policy block
// ----------------------------------------------------------------------------
`default_nettype none

package ipp_pkg;

  // request codes
  localparam logic [2:0] ReqAdd      = 3'd0;
  localparam logic [2:0] ReqUpdate   = 3'd1;
  localparam logic [2:0] ReqRemove   = 3'd2;
  localparam logic [2:0] ReqSelect   = 3'd3;
  localparam logic [2:0] ReqSimulate = 3'd4;

  // status codes
  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatNoInst    = 3'd1;
  localparam logic [2:0] StatBadLetter = 3'd2;
  localparam logic [2:0] StatFull      = 3'd3;
  localparam logic [2:0] StatUnknownId = 3'd4;

  // policy modes
  localparam logic [1:0] ModeRoundRobin = 2'd0;
  localparam logic [1:0] ModeMostFree   = 2'd1;
  localparam logic [1:0] ModeKeyRange   = 2'd2;

  // configuration register indexes
  localparam logic [0:0] CfgPolicyMode = 1'b0;
  localparam logic [0:0] CfgEntriesPer = 1'b1;

  // key letter range: lower-case letters a..z
  localparam int unsigned LetterSpan = 26;
  localparam logic [7:0]  LetterBase = 8'd96;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  instance_id;
    logic [15:0] free_entries;
    logic [7:0]  key_first_char;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_slot;
    logic [7:0] chosen_id;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] free_cnt;
  } slot_entry_t;

endpackage

`default_nettype wire

/* rtl/instance_placement_policy_unit.sv */
// ----------------------------------------------------------------------------
// instance_placement_policy_unit
// picks the storage instance that receives a new key (round robin, most free
// entries, or key letter range) and maintains the instance table
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one request item; output
//   channel: out_valid_o / out_stall_i carry one result item per request.
//   configuration: cfg_we_i writes policy_mode (index 0) or
//   entries_per_instance (index 1); write only while the block is idle.
// sequencing
//   one request at a time; the table sits in a small memory with one read
//   port and registered read data, so every slot visited takes a read state
//   and a check state. add / update / remove / most-free select scan up to
//   n slots (n = table fill, n <= MAX_INSTANCES); a remove stops scanning at
//   the match and then shifts each later slot with a read and a write state.
//   round robin select reads one slot. key range select runs the subtract-26
//   loop that forms the quotient, then reads the chosen slot.
// reset
//   table empties (fill count and pointer clear), both registers go to zero;
//   table contents are not cleared, only entries below the fill are read.
// stalls
//   a finished result waits in the output register; a new request may be
//   taken meanwhile and its result is held back until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module instance_placement_policy_unit #(
  parameter int unsigned MAX_INSTANCES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  // request channel
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire ipp_pkg::in_item_t  in_item_i,
  // result channel
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      ipp_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int unsigned CntW = $clog2(MAX_INSTANCES + 1);
  localparam int unsigned RemW = $clog2(ipp_pkg::LetterSpan * MAX_INSTANCES +
                                        ipp_pkg::LetterSpan);

  // sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SCAN_RD    = 4'd1;
  localparam logic [3:0] S_SCAN_CHK   = 4'd2;
  localparam logic [3:0] S_SHIFT_RD   = 4'd3;
  localparam logic [3:0] S_SHIFT_WR   = 4'd4;
  localparam logic [3:0] S_DIV        = 4'd5;
  localparam logic [3:0] S_FETCH_RD   = 4'd6;
  localparam logic [3:0] S_FETCH_WAIT = 4'd7;
  localparam logic [3:0] S_RESP       = 4'd8;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [1:0]  mode_q;
  logic [15:0] epi_q;

  // table control
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rr_q, rr_d;

  // latched request
  logic [2:0]  req_q, req_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] fe_q, fe_d;

  // working registers of the shared scan / divide unit
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [15:0]     best_q, best_d;
  logic [7:0]      res_id_q, res_id_d;
  logic [2:0]      status_q, status_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [CntW-1:0] quo_q, quo_d;

  // output register
  logic               out_valid_q, out_valid_d;
  ipp_pkg::out_item_t out_q, out_d;

  // table memory, one write and one registered read per cycle
  ipp_pkg::slot_entry_t mem [MAX_INSTANCES];
  ipp_pkg::slot_entry_t rd_data_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [IdxW-1:0]      mem_raddr;
  ipp_pkg::slot_entry_t mem_wdata;

  logic            accept;
  logic            letter_ok;
  logic [4:0]      letter_c;
  logic [CntW-1:0] rr_sel;
  logic [CntW-1:0] rr_next;
  logic [CntW:0]   idx_plus1;
  logic [CntW-1:0] idx_inc;
  logic [31:0]     slot_wide;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign letter_ok = in_item_i.key_first_char inside
                     {[ipp_pkg::LetterBase + 8'd1 :
                       ipp_pkg::LetterBase + 8'(ipp_pkg::LetterSpan)]};
  assign letter_c  = 5'(in_item_i.key_first_char - ipp_pkg::LetterBase);

  // pointer outside the table is treated as slot zero
  assign rr_sel    = (CntW'(rr_q) < count_q) ? CntW'(rr_q) : '0;
  assign rr_next   = rr_sel + CntW'(1);
  assign idx_plus1 = {1'b0, idx_q} + (CntW + 1)'(1);
  assign idx_inc   = idx_q + CntW'(1);
  assign slot_wide = 32'(slot_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ipp_pkg::ModeRoundRobin;
      epi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipp_pkg::CfgPolicyMode: mode_q <= cfg_data_i[1:0];
        ipp_pkg::CfgEntriesPer: epi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rr_d        = rr_q;
    req_d       = req_q;
    id_d        = id_q;
    fe_d        = fe_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    best_d      = best_q;
    res_id_d    = res_id_q;
    status_d    = status_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d    = in_item_i.req_type;
          id_d     = in_item_i.instance_id;
          fe_d     = in_item_i.free_entries;
          idx_d    = '0;
          slot_d   = '0;
          best_d   = '0;
          res_id_d = '0;
          status_d = ipp_pkg::StatOk;
          case (in_item_i.req_type)
            ipp_pkg::ReqAdd, ipp_pkg::ReqUpdate, ipp_pkg::ReqRemove: begin
              state_d = S_SCAN_RD;
            end
            ipp_pkg::ReqSelect, ipp_pkg::ReqSimulate: begin
              if (count_q == '0) begin
                status_d = ipp_pkg::StatNoInst;
                state_d  = S_RESP;
              end else begin
                case (mode_q)
                  ipp_pkg::ModeMostFree: begin
                    state_d = S_SCAN_RD;
                  end
                  ipp_pkg::ModeKeyRange: begin
                    if (!letter_ok) begin
                      status_d = ipp_pkg::StatBadLetter;
                      state_d  = S_RESP;
                    end else begin
                      // ceil(c*n/26) = (c*n + 25) / 26
                      rem_d   = RemW'(letter_c) * RemW'(count_q) +
                                RemW'(ipp_pkg::LetterSpan - 1);
                      quo_d   = '0;
                      state_d = S_DIV;
                    end
                  end
                  default: begin
                    slot_d = IdxW'(rr_sel);
                    if (in_item_i.req_type == ipp_pkg::ReqSelect) begin
                      rr_d = (rr_next >= count_q) ? '0 : IdxW'(rr_next);
                    end
                    state_d = S_FETCH_RD;
                  end
                endcase
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_q < count_q) begin
          mem_raddr = idx_q[IdxW-1:0];
          state_d   = S_SCAN_CHK;
        end else begin
          // scan finished without a match (or argmax done)
          state_d = S_RESP;
          case (req_q)
            ipp_pkg::ReqAdd: begin
              if (count_q >= CntW'(MAX_INSTANCES)) begin
                status_d = ipp_pkg::StatFull;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IdxW-1:0];
                mem_wdata = '{id: id_q, free_cnt: epi_q};
                count_d   = count_q + CntW'(1);
              end
            end
            ipp_pkg::ReqUpdate, ipp_pkg::ReqRemove: begin
              status_d = ipp_pkg::StatUnknownId;
            end
            default: ;
          endcase
        end
      end

      S_SCAN_CHK: begin
        if (req_q inside {ipp_pkg::ReqSelect, ipp_pkg::ReqSimulate}) begin
          // most free: strict greater keeps the lowest slot on ties
          if (idx_q == '0 || rd_data_q.free_cnt > best_q) begin
            best_d   = rd_data_q.free_cnt;
            slot_d   = idx_q[IdxW-1:0];
            res_id_d = rd_data_q.id;
          end
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end else if (rd_data_q.id == id_q) begin
          case (req_q)
            ipp_pkg::ReqUpdate: begin
              mem_we    = 1'b1;
              mem_waddr = idx_q[IdxW-1:0];
              mem_wdata = '{id: id_q, free_cnt: fe_q};
              state_d   = S_RESP;
            end
            ipp_pkg::ReqRemove: begin
              state_d = S_SHIFT_RD;
            end
            default: begin
              // add of an id already present
              state_d = S_RESP;
            end
          endcase
        end else begin
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_plus1 < {1'b0, count_q}) begin
          mem_raddr = idx_plus1[IdxW-1:0];
          state_d   = S_SHIFT_WR;
        end else begin
          count_d = count_q - CntW'(1);
          rr_d    = '0;
          state_d = S_RESP;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[IdxW-1:0];
        mem_wdata = rd_data_q;
        idx_d     = idx_inc;
        state_d   = S_SHIFT_RD;
      end

      S_DIV: begin
        // one subtract of 26 per cycle
        if (rem_q >= RemW'(ipp_pkg::LetterSpan)) begin
          rem_d = rem_q - RemW'(ipp_pkg::LetterSpan);
          quo_d = quo_q + CntW'(1);
        end else begin
          slot_d  = IdxW'(quo_q - CntW'(1));
          state_d = S_FETCH_RD;
        end
      end

      S_FETCH_RD: begin
        mem_raddr = slot_q;
        state_d   = S_FETCH_WAIT;
      end

      S_FETCH_WAIT: begin
        res_id_d = rd_data_q.id;
        state_d  = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.chosen_slot = slot_wide[3:0];
          out_d.chosen_id   = res_id_q;
          out_d.status      = status_q;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    fe_q     <= fe_d;
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    best_q   <= best_d;
    res_id_q <= res_id_d;
    status_q <= status_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

/* verif/tb_instance_placement_policy_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_instance_placement_policy_unit
// self-checking bench for the instance placement policy block: a small
// tracker class keeps its own copy of the instance table, predicts the
// result of every accepted request and checks the results in order, while
// plain tasks drive directed and random requests under several idle profiles
// ----------------------------------------------------------------------------

module tb_instance_placement_policy_unit;

  localparam int unsigned SlotCount   = 16;
  localparam int unsigned IdPool      = 20;      // ids mostly drawn from a small pool
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PhaseItems  = 105;
  localparam int unsigned HoldOff     = 400;     // long receiver hold-off, in cycles
  localparam int unsigned LatencyTail = 100;     // quiet cycles after the last result
  localparam int unsigned CycleLimit  = 400000;

  // ---------------------------------------------------------------------------
  // placement tracker: mirrors the table and holds the expected picks
  // ---------------------------------------------------------------------------
  class placement_tracker;
    logic [7:0]         slot_id   [SlotCount];
    logic [15:0]        slot_free [SlotCount];
    int unsigned        fill;
    int unsigned        rr_ptr;
    logic [1:0]         mode;
    logic [15:0]        entries_per;
    ipp_pkg::out_item_t expected_picks [$];
    int unsigned        errors;
    int unsigned        noted;
    int unsigned        checked;

    function new();
      fill        = 0;
      rr_ptr      = 0;
      mode        = ipp_pkg::ModeRoundRobin;
      entries_per = '0;
      errors      = 0;
      noted       = 0;
      checked     = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == ipp_pkg::CfgPolicyMode) mode = val[1:0];
      else entries_per = val;
    endfunction

    function int find_slot(logic [7:0] id);
      for (int i = 0; i < int'(fill); i++)
        if (slot_id[i] == id) return i;
      return -1;
    endfunction

    // work out the result of one accepted request and queue it
    function void note_request(ipp_pkg::in_item_t req);
      ipp_pkg::out_item_t res;
      int                 k;
      int unsigned        s;
      int unsigned        c;
      res = '0;
      s   = 0;
      case (req.req_type)
        ipp_pkg::ReqAdd: begin
          // an id already present is silently accepted
          if (find_slot(req.instance_id) < 0) begin
            if (fill >= SlotCount) begin
              res.status = ipp_pkg::StatFull;
            end else begin
              slot_id[fill]   = req.instance_id;
              slot_free[fill] = entries_per;
              fill++;
            end
          end
        end
        ipp_pkg::ReqUpdate: begin
          k = find_slot(req.instance_id);
          if (k < 0) res.status = ipp_pkg::StatUnknownId;
          else slot_free[k] = req.free_entries;
        end
        ipp_pkg::ReqRemove: begin
          k = find_slot(req.instance_id);
          if (k < 0) begin
            res.status = ipp_pkg::StatUnknownId;
          end else begin
            for (int i = k; i + 1 < int'(fill); i++) begin
              slot_id[i]   = slot_id[i+1];
              slot_free[i] = slot_free[i+1];
            end
            fill--;
            rr_ptr = 0;
          end
        end
        ipp_pkg::ReqSelect, ipp_pkg::ReqSimulate: begin
          if (fill == 0) begin
            res.status = ipp_pkg::StatNoInst;
          end else if (mode == ipp_pkg::ModeMostFree) begin
            // first slot with the largest count wins
            for (int i = 1; i < int'(fill); i++)
              if (slot_free[i] > slot_free[s]) s = i;
          end else if (mode == ipp_pkg::ModeKeyRange) begin
            if (req.key_first_char <= ipp_pkg::LetterBase ||
                req.key_first_char > ipp_pkg::LetterBase + ipp_pkg::LetterSpan) begin
              res.status = ipp_pkg::StatBadLetter;
            end else begin
              c = req.key_first_char - ipp_pkg::LetterBase;
              s = (c * fill + ipp_pkg::LetterSpan - 1) / ipp_pkg::LetterSpan - 1;
            end
          end else begin
            // round robin, also taken for the unused mode code
            s = (rr_ptr < fill) ? rr_ptr : 0;
            if (req.req_type == ipp_pkg::ReqSelect) rr_ptr = (s + 1 >= fill) ? 0 : s + 1;
          end
          if (res.status == ipp_pkg::StatOk) begin
            res.chosen_slot = s[3:0];
            res.chosen_id   = slot_id[s];
          end
        end
        default: ;
      endcase
      expected_picks.push_back(res);
      noted++;
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(ipp_pkg::out_item_t got);
      ipp_pkg::out_item_t want;
      if (expected_picks.size() == 0) begin
        $display("%0t: result with nothing expected, got slot %0d id %0d status %0d",
                 $time, got.chosen_slot, got.chosen_id, got.status);
        errors++;
        return;
      end
      want = expected_picks.pop_front();
      compare_field("chosen_slot", 8'(want.chosen_slot), 8'(got.chosen_slot));
      compare_field("chosen_id", want.chosen_id, got.chosen_id);
      compare_field("status", 8'(want.status), 8'(got.status));
      checked++;
    endfunction

    function void check_leftover();
      if (expected_picks.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_picks.size());
        errors += expected_picks.size();
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block hookup, every input known from time zero
  // ---------------------------------------------------------------------------
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [0:0]         cfg_idx_i  = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  ipp_pkg::in_item_t  in_item_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ipp_pkg::out_item_t out_item_o;

  instance_placement_policy_unit #(
    .MAX_INSTANCES(SlotCount)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  placement_tracker tracker;

  // idle profile knobs, percent per cycle
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  // cycles left in a forced receiver hold-off
  int unsigned hold_cycles     = 0;
  int unsigned cycle_count     = 0;

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit, in case the block hangs
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("%0t: timeout after %0d cycles, %0d results still expected",
                 $time, CycleLimit, tracker.expected_picks.size());
        $display("** instance_placement_policy_unit: FAILED **");
        $finish;
      end
    end
  end

  // result side: check what was taken at this edge, then pick the next stall
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) tracker.check_result(out_item_o);
      if (hold_cycles > 0) begin
        // long hold-off so the block fills and stalls its input
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drive tasks
  // ---------------------------------------------------------------------------

  // offer one item, with random gaps ahead of it, and wait until it is taken;
  // valid stays high on return so back-to-back items need no extra edge
  task automatic send_request(input ipp_pkg::in_item_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    tracker.note_request(req);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
  endtask

  // both registers, only once the block has gone idle
  task automatic configure(input logic [1:0] mode, input logic [15:0] entries);
    drain();
    write_cfg(ipp_pkg::CfgPolicyMode, {14'd0, mode});
    write_cfg(ipp_pkg::CfgEntriesPer, entries);
    cfg_we_i <= 1'b0;
  endtask

  function automatic ipp_pkg::in_item_t make_req(logic [2:0] kind, logic [7:0] id,
                                                 logic [15:0] free_cnt, logic [7:0] key);
    ipp_pkg::in_item_t r;
    r.req_type       = kind;
    r.instance_id    = id;
    r.free_entries   = free_cnt;
    r.key_first_char = key;
    return r;
  endfunction

  // random request: mostly pool ids so adds, updates and removes hit the table
  function automatic ipp_pkg::in_item_t random_request();
    ipp_pkg::in_item_t r;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 30)      r.req_type = ipp_pkg::ReqAdd;
    else if (pick < 45) r.req_type = ipp_pkg::ReqUpdate;
    else if (pick < 57) r.req_type = ipp_pkg::ReqRemove;
    else if (pick < 82) r.req_type = ipp_pkg::ReqSelect;
    else if (pick < 97) r.req_type = ipp_pkg::ReqSimulate;
    else                r.req_type = 3'($urandom_range(7, 5));   // unused codes
    if ($urandom_range(99) < 85) r.instance_id = 8'($urandom_range(IdPool - 1) * 37);
    else r.instance_id = 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       r.free_entries = 16'($urandom_range(65535));
      1:       r.free_entries = 16'($urandom_range(7));          // ties for most free
      2:       r.free_entries = 16'hFFFF;
      default: r.free_entries = 16'h0000;
    endcase
    pick = $urandom_range(99);
    if (pick < 80) begin
      r.key_first_char = 8'($urandom_range(122, 97));
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0:       r.key_first_char = ipp_pkg::LetterBase;
        1:       r.key_first_char = ipp_pkg::LetterBase + 8'd1;
        2:       r.key_first_char = ipp_pkg::LetterBase + 8'(ipp_pkg::LetterSpan);
        default: r.key_first_char = ipp_pkg::LetterBase + 8'(ipp_pkg::LetterSpan) + 8'd1;
      endcase
    end else begin
      r.key_first_char = 8'($urandom_range(255));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] entries;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, absent ids, unused code, duplicates, wrap
    configure(ipp_pkg::ModeRoundRobin, 16'hFFFF);
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, 8'd97));
    send_request(make_req(ipp_pkg::ReqSimulate, 8'd0, 16'd0, 8'd97));
    send_request(make_req(ipp_pkg::ReqUpdate, 8'd5, 16'h1234, 8'd0));
    send_request(make_req(ipp_pkg::ReqRemove, 8'd5, 16'd0, 8'd0));
    send_request(make_req(3'd7, 8'hFF, 16'hFFFF, 8'hFF));
    send_request(make_req(ipp_pkg::ReqAdd, 8'hFF, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqAdd, 8'h00, 16'hFFFF, 8'hFF));
    send_request(make_req(ipp_pkg::ReqAdd, 8'hFF, 16'd7, 8'd0));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqSimulate, 8'd0, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqUpdate, 8'hFF, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqRemove, 8'hFF, 16'd0, 8'd0));

    // directed: fill the table, overflow, letter edges
    configure(ipp_pkg::ModeKeyRange, 16'h0000);
    for (int i = 1; i < int'(SlotCount); i++)
      send_request(make_req(ipp_pkg::ReqAdd, 8'(i), 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqAdd, 8'h80, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, ipp_pkg::LetterBase));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, ipp_pkg::LetterBase + 8'd1));
    send_request(make_req(ipp_pkg::ReqSimulate, 8'd0, 16'd0,
                          ipp_pkg::LetterBase + 8'(ipp_pkg::LetterSpan)));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0,
                          ipp_pkg::LetterBase + 8'(ipp_pkg::LetterSpan) + 8'd1));

    // directed: most free with a clear winner, then a tie
    configure(ipp_pkg::ModeMostFree, 16'h0000);
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, 8'd0));
    send_request(make_req(ipp_pkg::ReqUpdate, 8'd9, 16'hFFFF, 8'd0));
    send_request(make_req(ipp_pkg::ReqSelect, 8'd0, 16'd0, 8'd0));

    // random phases: every mode code, four idle profiles
    for (int p = 0; p < int'(RandPhases); p++) begin
      case (p % 4)
        0:       entries = 16'h0000;
        1:       entries = 16'hFFFF;
        2:       entries = 16'($urandom_range(65535));
        default: entries = 16'($urandom_range(3));
      endcase
      configure(2'(p % 4), entries);
      case ((p / 2) % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // one phase starts with the result side held off while items keep coming
      if (p == 1) hold_cycles = HoldOff;
      for (int n = 0; n < int'(PhaseItems); n++) send_request(random_request());
    end

    // wind down and report
    drain();
    repeat (LatencyTail) @(posedge clk_i);
    tracker.check_leftover();
    $display("run covered %0d requests and %0d checked results", tracker.noted,
             tracker.checked);
    $display("over %0d random phases with all policy mode codes and idle profiles",
             RandPhases);
    if (tracker.errors == 0) begin
      $display("** instance_placement_policy_unit: PASSED **");
    end else begin
      $display("** instance_placement_policy_unit: FAILED **");
    end
    $finish;
  end

endmodule
